[src/fbp_pkg.sv]
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types, constants and helpers of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbp_pkg;

  localparam int MAX_BLOCKS_DEF = 256;

  localparam int ADDR_W = 32;  // byte addresses
  localparam int POOL_W = 24;  // pool length, also dividend width
  localparam int BLK_W  = 16;  // requested block length
  localparam int LEN_W  = 17;  // rounded block length (up to 65536)
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W = 2;

  // slave tdata: address, to_head, zero fill to whole bytes
  localparam int IN_DATA_W = ((ADDR_W + 1 + 7) / 8) * 8;

  localparam logic [POOL_W-1:0] POOL_RST  = POOL_W'(1024);
  localparam logic [BLK_W-1:0]  BLOCK_RST = BLK_W'(32);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_POOL  = 2'd1,
    REG_BLOCK = 2'd2
  } reg_e;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } unit_req_t;

  // block length rounded up to a multiple of four
  function automatic logic [LEN_W-1:0] round_len(input logic [BLK_W-1:0] blk);
    logic [LEN_W-1:0] sum;
    sum = LEN_W'(blk) + LEN_W'(3);
    return {sum[LEN_W-1:2], 2'b00};
  endfunction

endpackage

[src/fbp_iter_unit.sv]
// ----------------------------------------------------------------------------
// fbp_iter_unit
// Shared bit-serial unit: restoring divide or shift-add multiply on one adder.
// ----------------------------------------------------------------------------
module fbp_iter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbp_pkg::unit_req_t            req_i,
  input  logic [fbp_pkg::POOL_W-1:0]    opa_i,   // dividend or multiplier
  input  logic [fbp_pkg::LEN_W-1:0]     opb_i,   // divisor or multiplicand
  output logic                          done_o,
  output logic [fbp_pkg::POOL_W-1:0]    quot_o,
  output logic [fbp_pkg::LEN_W-1:0]     rem_o,
  output logic [fbp_pkg::ADDR_W-1:0]    prod_o
);

  localparam int AW    = fbp_pkg::ADDR_W;
  localparam int PW    = fbp_pkg::POOL_W;
  localparam int StepW = $clog2(PW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  fbp_pkg::op_e    op_q, op_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [PW-1:0]   a_q, a_d;
  logic [AW-1:0]   acc_q, acc_d;
  logic [AW-1:0]   b_q, b_d;

  logic            sub;
  logic [AW-1:0]   add_a, add_b;
  logic [AW:0]     sum;

  // the one adder, subtracting while dividing
  always_comb begin
    sub   = (op_q == fbp_pkg::OP_DIV);
    add_a = sub ? {acc_q[AW-2:0], a_q[PW-1]} : acc_q;
    add_b = sub ? ~b_q : b_q;
    sum   = {1'b0, add_a} + {1'b0, add_b} + (AW+1)'(sub);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    acc_d  = acc_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      a_d    = opa_i;
      acc_d  = '0;
      b_d    = AW'(opb_i);
    end else if (busy_q) begin
      if (op_q == fbp_pkg::OP_DIV) begin
        // carry out set means the shifted remainder covers the divisor
        acc_d = sum[AW] ? sum[AW-1:0] : add_a;
        a_d   = {a_q[PW-2:0], sum[AW]};
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(PW - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        if (a_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          if (a_q[0]) begin
            acc_d = sum[AW-1:0];
          end
          a_d = a_q >> 1;
          b_d = b_q << 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= fbp_pkg::OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign quot_o = a_q;
  assign rem_o  = acc_q[fbp_pkg::LEN_W-1:0];
  assign prod_o = acc_q;

endmodule

[src/fixed_block_pool_head_tail_free_unit.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_head_tail_free_unit
// Fixed-size block pool allocator with a head/tail linked free list.
// ----------------------------------------------------------------------------
// Commands arrive on the slave stream (tuser: command; tdata: address,
// to_head). Each transaction returns exactly one result on the master
// stream (tdata: ok, block_address, free_count).
// Registers base_address, pool_bytes and block_bytes are written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only while
// the block is idle, which the block itself does not enforce.
// One command is in work at a time; s_axis_tready is low meanwhile.
// Work per command, done by the shared bit-serial divide/multiply unit:
//   allocate: shift-add multiply over the bit length of the head index
//   free:     24-step divide of the offset, one more state on append
//   init:     24-step divide, then one link table write per block
//   no-op, empty allocate, early free reject: no work in the unit
// The next-link table is a single-port-write, registered-read memory.
// Reset empties the list and loads the register defaults; the table itself
// is not cleared. A stalled master keeps its result in the output register;
// the next command is accepted meanwhile and its result waits until the
// output register frees up.
// ----------------------------------------------------------------------------
module fixed_block_pool_head_tail_free_unit #(
  parameter  int MaxBlocks = fbp_pkg::MAX_BLOCKS_DEF,
  localparam int CntW      = $clog2(MaxBlocks + 1),
  localparam int OutW      = ((1 + fbp_pkg::ADDR_W + CntW + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fbp_pkg::ADDR_W-1:0]       cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fbp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // address, to_head, zero fill
  input  logic [fbp_pkg::CMD_W-1:0]        s_axis_tuser,  // command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [OutW-1:0]                  m_axis_tdata   // ok, block_address, free_count
);

  localparam int AW = fbp_pkg::ADDR_W;
  localparam int PW = fbp_pkg::POOL_W;
  localparam int LW = fbp_pkg::LEN_W;
  localparam int IW = $clog2(MaxBlocks);
  localparam logic [CntW-1:0] LinkEnd = CntW'(MaxBlocks);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_FILL  = 7'b0010000,
    ST_LINK  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [AW-1:0]              base_q;
  logic [PW-1:0]              pool_q;
  logic [fbp_pkg::BLK_W-1:0]  blk_q;
  logic [LW-1:0]              len;

  // list state
  logic [IW-1:0]   head_q, head_d, tail_q, tail_d;
  logic            head_vld_q, head_vld_d, tail_vld_q, tail_vld_d;
  logic [CntW-1:0] count_q, count_d;

  // command in work
  fbp_pkg::cmd_e   cmd_q, cmd_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic            to_head_q, to_head_d;
  logic [PW-1:0]   off_q, off_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   fill_q, fill_d;
  logic [CntW-1:0] num_q, num_d;
  logic            res_ok_q, res_ok_d;
  logic [AW-1:0]   res_addr_q, res_addr_d;

  // output register
  logic            m_vld_q, m_vld_d;
  logic [OutW-1:0] m_data_q, m_data_d;

  // next-link table
  logic [CntW-1:0] link_mem [MaxBlocks];
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [CntW-1:0] mem_wdata;
  logic [CntW-1:0] mem_rdata_q;

  // shared unit
  fbp_pkg::unit_req_t   unit_req;
  logic [PW-1:0]        unit_a;
  logic                 unit_done;
  logic [PW-1:0]        unit_quot;
  logic [LW-1:0]        unit_rem;
  logic [AW-1:0]        unit_prod;

  logic            in_fire;
  logic [AW:0]     pool_end;
  logic            bad_addr;
  logic [AW-1:0]   off_full;
  logic [PW:0]     off_next;
  logic [CntW-1:0] fill_next;

  assign len     = fbp_pkg::round_len(blk_q);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  fbp_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .opa_i  (unit_a),
    .opb_i  (len),
    .done_o (unit_done),
    .quot_o (unit_quot),
    .rem_o  (unit_rem),
    .prod_o (unit_prod)
  );

  always_comb begin
    pool_end  = {1'b0, base_q} + (AW+1)'(pool_q);
    bad_addr  = (addr_q == '0) || (len == '0) || (addr_q < base_q) ||
                ({1'b0, addr_q} >= pool_end);
    off_full  = addr_q - base_q;
    off_next  = {1'b0, off_q} + (PW+1)'(len);
    fill_next = CntW'(fill_q) + CntW'(1);
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    count_d    = count_q;
    cmd_d      = cmd_q;
    addr_d     = addr_q;
    to_head_d  = to_head_q;
    off_d      = off_q;
    idx_d      = idx_q;
    fill_d     = fill_q;
    num_d      = num_q;
    res_ok_d   = res_ok_q;
    res_addr_d = res_addr_q;
    m_vld_d    = m_vld_q && !m_axis_tready;
    m_data_d   = m_data_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = LinkEnd;
    unit_req   = '{start: 1'b0, op: fbp_pkg::OP_DIV};
    unit_a     = pool_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d      = fbp_pkg::cmd_e'(s_axis_tuser);
          addr_d     = s_axis_tdata[AW-1:0];
          to_head_d  = s_axis_tdata[AW];
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          case (fbp_pkg::cmd_e'(s_axis_tuser))
            fbp_pkg::CMD_INIT: begin
              res_ok_d = 1'b1;
              if (len == '0) begin
                head_vld_d = 1'b0;
                tail_vld_d = 1'b0;
                head_d     = '0;
                tail_d     = '0;
                count_d    = '0;
                state_d    = ST_DONE;
              end else begin
                unit_req = '{start: 1'b1, op: fbp_pkg::OP_DIV};
                unit_a   = pool_q;
                state_d  = ST_DIV;
              end
            end
            fbp_pkg::CMD_ALLOC: begin
              if (head_vld_q) begin
                unit_req = '{start: 1'b1, op: fbp_pkg::OP_MUL};
                unit_a   = PW'(head_q);
                state_d  = ST_MUL;
              end else begin
                state_d = ST_DONE;
              end
            end
            fbp_pkg::CMD_FREE: begin
              state_d = ST_CHECK;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (bad_addr) begin
          state_d = ST_DONE;
        end else begin
          // offset stays below pool_bytes, so it fits the dividend
          off_d    = off_full[PW-1:0];
          unit_req = '{start: 1'b1, op: fbp_pkg::OP_DIV};
          unit_a   = off_full[PW-1:0];
          state_d  = ST_DIV;
        end
      end

      ST_DIV: begin
        if (unit_done) begin
          if (cmd_q == fbp_pkg::CMD_INIT) begin
            if (unit_quot >= PW'(MaxBlocks)) begin
              num_d = LinkEnd;
            end else begin
              num_d = CntW'(unit_quot);
            end
            if (unit_quot == '0) begin
              head_vld_d = 1'b0;
              tail_vld_d = 1'b0;
              head_d     = '0;
              tail_d     = '0;
              count_d    = '0;
              state_d    = ST_DONE;
            end else begin
              fill_d  = '0;
              state_d = ST_FILL;
            end
          end else begin
            // block must be aligned, lie fully inside the pool and fit the table
            if ((unit_rem != '0) || (unit_quot >= PW'(MaxBlocks)) ||
                (off_next > (PW+1)'(pool_q))) begin
              state_d = ST_DONE;
            end else begin
              idx_d    = unit_quot[IW-1:0];
              res_ok_d = 1'b1;
              if (to_head_q) begin
                mem_we     = 1'b1;
                mem_waddr  = unit_quot[IW-1:0];
                mem_wdata  = head_vld_q ? CntW'(head_q) : LinkEnd;
                head_d     = unit_quot[IW-1:0];
                head_vld_d = 1'b1;
                if (!tail_vld_q) begin
                  tail_d     = unit_quot[IW-1:0];
                  tail_vld_d = 1'b1;
                end
                if (count_q < LinkEnd) begin
                  count_d = count_q + CntW'(1);
                end
                state_d = ST_DONE;
              end else begin
                if (tail_vld_q) begin
                  mem_we    = 1'b1;
                  mem_waddr = tail_q;
                  mem_wdata = CntW'(unit_quot[IW-1:0]);
                end else begin
                  head_d     = unit_quot[IW-1:0];
                  head_vld_d = 1'b1;
                end
                state_d = ST_LINK;
              end
            end
          end
        end
      end

      ST_LINK: begin
        // new tail ends the list
        mem_we     = 1'b1;
        mem_waddr  = idx_q;
        mem_wdata  = LinkEnd;
        tail_d     = idx_q;
        tail_vld_d = 1'b1;
        if (count_q < LinkEnd) begin
          count_d = count_q + CntW'(1);
        end
        state_d = ST_DONE;
      end

      ST_MUL: begin
        if (unit_done) begin
          res_ok_d   = 1'b1;
          res_addr_d = base_q + unit_prod;
          if (mem_rdata_q >= LinkEnd) begin
            head_vld_d = 1'b0;
            tail_vld_d = 1'b0;
            head_d     = '0;
            tail_d     = '0;
          end else begin
            head_d = mem_rdata_q[IW-1:0];
          end
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
          end
          state_d = ST_DONE;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        if (fill_next == num_q) begin
          mem_wdata  = LinkEnd;
          head_d     = '0;
          tail_d     = fill_q;
          head_vld_d = 1'b1;
          tail_vld_d = 1'b1;
          count_d    = num_q;
          state_d    = ST_DONE;
        end else begin
          mem_wdata = fill_next;
          fill_d    = fill_q + IW'(1);
        end
      end

      ST_DONE: begin
        if (!m_vld_q || m_axis_tready) begin
          m_vld_d  = 1'b1;
          m_data_d = OutW'({count_q, res_addr_q, res_ok_q});
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      base_q     <= '0;
      pool_q     <= fbp_pkg::POOL_RST;
      blk_q      <= fbp_pkg::BLOCK_RST;
      head_q     <= '0;
      tail_q     <= '0;
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
      count_q    <= '0;
      cmd_q      <= fbp_pkg::CMD_NOP;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
      count_q    <= count_d;
      cmd_q      <= cmd_d;
      m_vld_q    <= m_vld_d;
      if (cfg_we_i) begin
        case (fbp_pkg::reg_e'(cfg_index_i))
          fbp_pkg::REG_BASE:  base_q <= cfg_data_i;
          fbp_pkg::REG_POOL:  pool_q <= cfg_data_i[PW-1:0];
          fbp_pkg::REG_BLOCK: blk_q  <= cfg_data_i[fbp_pkg::BLK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_d_reg: begin
      addr_q     <= addr_d;
      to_head_q  <= to_head_d;
      off_q      <= off_d;
      idx_q      <= idx_d;
      fill_q     <= fill_d;
      num_q      <= num_d;
      res_ok_q   <= res_ok_d;
      res_addr_q <= res_addr_d;
      m_data_q   <= m_data_d;
    end
  end

  // link table: one write port, registered read at the list head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= link_mem[head_q];
  end

endmodule

[src/fbp_checker.sv]
// ----------------------------------------------------------------------------
// fbp_checker
// Port-level checks of the block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbp_checker #(
  parameter  int MaxBlocks = fbp_pkg::MAX_BLOCKS_DEF,
  localparam int CntW      = $clog2(MaxBlocks + 1),
  localparam int OutW      = ((1 + fbp_pkg::ADDR_W + CntW + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [OutW-1:0]                  m_axis_tdata
);

  localparam int AW = fbp_pkg::ADDR_W;

  logic            res_ok;
  logic [AW-1:0]   res_addr;
  logic [CntW-1:0] res_count;

  assign res_ok    = m_axis_tdata[0];
  assign res_addr  = m_axis_tdata[AW:1];
  assign res_count = m_axis_tdata[AW+CntW:AW+1];

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one command in work at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while busy");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_count <= CntW'(MaxBlocks))
    else $error("free count above capacity");

  // failed commands never hand out an address
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_ok |-> res_addr == '0)
    else $error("address given on failure");

endmodule

bind fixed_block_pool_head_tail_free_unit fbp_checker #(.MaxBlocks(MaxBlocks)) u_fbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/fixed_block_pool_head_tail_free_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_head_tail_free_unit_tb
// Self-checking bench for the block pool allocator. Commands go in on the
// slave stream and a shadow free list in a scoreboard class predicts ok,
// block address and free count for each one. Results on the master stream
// are compared in order. The run walks several pool geometries, including
// zero blocks, address wrap, count saturation and a cyclic list.
// ----------------------------------------------------------------------------
module fixed_block_pool_head_tail_free_unit_tb;
  import fbp_pkg::*;

  localparam int POOL_BLOCKS = MAX_BLOCKS_DEF;
  localparam int CNT_W       = $clog2(POOL_BLOCKS + 1);
  localparam int OUT_W       = ((1 + ADDR_W + CNT_W + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] LINK_END = CNT_W'(POOL_BLOCKS);
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic             ok;
    logic [31:0]      addr;
    logic [CNT_W-1:0] cnt;
  } pool_result_t;

  class pool_scoreboard;
    logic [31:0]       base_addr;
    logic [23:0]       pool_len;
    logic [15:0]       blk_req;
    logic [CNT_W-1:0]  next_link[POOL_BLOCKS];
    logic [7:0]        head_idx;
    logic [7:0]        tail_idx;
    logic              head_ok;
    logic              tail_ok;
    logic [CNT_W-1:0]  free_cnt;
    pool_result_t      expected_q[$];
    logic [31:0]       held_q[$];
    int                failures;

    function new();
      base_addr = '0;
      pool_len  = POOL_RST;
      blk_req   = BLOCK_RST;
      foreach (next_link[i]) next_link[i] = '0;
      head_idx  = '0;
      tail_idx  = '0;
      head_ok   = 1'b0;
      tail_ok   = 1'b0;
      free_cnt  = '0;
      failures  = 0;
    endfunction

    function void write_reg(reg_e idx, logic [31:0] value);
      case (idx)
        REG_BASE:  base_addr = value;
        REG_POOL:  pool_len = value[23:0];
        REG_BLOCK: blk_req = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned block_len();
      return ((int'(blk_req) + 3) / 4) * 4;
    endfunction

    function int unsigned block_count();
      int unsigned len;
      int unsigned n;
      len = block_len();
      if (len == 0) return 0;
      n = pool_len / len;
      return (n > POOL_BLOCKS) ? POOL_BLOCKS : n;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // advance the shadow free list by one accepted command
    function void note_command(cmd_e cmd, logic [31:0] addr, logic to_head);
      pool_result_t res;
      int unsigned  len;
      int unsigned  n;
      int unsigned  off;
      int unsigned  idx;
      logic [32:0]  pool_end;
      logic         fits;
      res = '0;
      len = block_len();
      n   = block_count();
      case (cmd)
        CMD_INIT: begin
          res.ok = 1'b1;
          held_q.delete();
          if (n == 0) begin
            head_ok  = 1'b0;
            tail_ok  = 1'b0;
            head_idx = '0;
            tail_idx = '0;
            free_cnt = '0;
          end else begin
            for (int i = 0; i < n; i++) begin
              next_link[i] = (i + 1 < n) ? CNT_W'(i + 1) : LINK_END;
            end
            head_idx = '0;
            tail_idx = 8'(n - 1);
            head_ok  = 1'b1;
            tail_ok  = 1'b1;
            free_cnt = CNT_W'(n);
          end
        end
        CMD_ALLOC: begin
          if (head_ok) begin
            idx = head_idx;
            if (next_link[idx] >= LINK_END) begin
              head_ok  = 1'b0;
              tail_ok  = 1'b0;
              head_idx = '0;
              tail_idx = '0;
            end else begin
              head_idx = next_link[idx][7:0];
            end
            if (free_cnt > 0) free_cnt--;
            res.ok   = 1'b1;
            res.addr = base_addr + 32'(idx * len);
            held_q.push_back(res.addr);
            if (held_q.size() > 512) void'(held_q.pop_front());
          end
        end
        CMD_FREE: begin
          pool_end = {1'b0, base_addr} + 33'(pool_len);
          fits = (addr != '0) && (len != 0) && (addr >= base_addr) &&
                 ({1'b0, addr} < pool_end);
          off = addr - base_addr;
          if (fits) fits = (off % len == 0) && (off / len < n);
          if (fits) begin
            idx = off / len;
            if (to_head) begin
              next_link[idx] = head_ok ? CNT_W'(head_idx) : LINK_END;
              head_idx = 8'(idx);
              head_ok  = 1'b1;
              if (!tail_ok) begin
                tail_idx = 8'(idx);
                tail_ok  = 1'b1;
              end
            end else begin
              if (!tail_ok) begin
                head_idx = 8'(idx);
                head_ok  = 1'b1;
              end else begin
                next_link[tail_idx] = CNT_W'(idx);
              end
              tail_idx = 8'(idx);
              tail_ok  = 1'b1;
              next_link[idx] = LINK_END;
            end
            if (free_cnt < POOL_BLOCKS) free_cnt++;
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.cnt = free_cnt;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      pool_result_t got;
      pool_result_t want;
      got.ok   = data[0];
      got.addr = data[32:1];
      got.cnt  = data[33 +: CNT_W];
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: ok=%0d addr=%h count=%0d",
                   got.ok, got.addr, got.cnt);
      end else begin
        want = expected_q.pop_front();
        if (got.ok !== want.ok || got.addr !== want.addr || got.cnt !== want.cnt) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected ok=%0d addr=%h count=%0d, got ok=%0d addr=%h count=%0d",
                     want.ok, want.addr, want.cnt, got.ok, got.addr, got.cnt);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [ADDR_W-1:0]    cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;  // address, to_head, zero fill
  logic [CMD_W-1:0]     s_axis_tuser  = '0;  // command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // ok, block_address, free_count

  pool_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int unsigned    results_seen = 0;

  fixed_block_pool_head_tail_free_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  // result side: random backpressure plus one long hold-off
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= 400) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_cmd(cmd_e cmd, logic [31:0] addr, logic to_head);
    if (!no_idle) begin
      while ($urandom_range(99) < 38) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_DATA_W'({to_head, addr});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, addr, to_head);
  endtask

  task automatic wait_idle(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic begin_phase(logic [31:0] base, logic [23:0] pool, logic [15:0] blk,
                             bit init_first);
    wait_idle(8);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_BASE;
    cfg_data_i  <= base;
    @(posedge clk_i);
    sb.write_reg(REG_BASE, base);
    cfg_index_i <= REG_POOL;
    cfg_data_i  <= 32'(pool);
    @(posedge clk_i);
    sb.write_reg(REG_POOL, 32'(pool));
    cfg_index_i <= REG_BLOCK;
    cfg_data_i  <= 32'(blk);
    @(posedge clk_i);
    sb.write_reg(REG_BLOCK, 32'(blk));
    cfg_we_i <= 1'b0;
    if (init_first) send_cmd(CMD_INIT, $urandom(), 1'($urandom_range(1)));
  endtask

  // mostly allocate and well-formed frees, with some rejects and re-inits
  task automatic random_run(int unsigned count);
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    logic [31:0] addr;
    cmd_e        cmd;
    repeat (count) begin
      pick = $urandom_range(99);
      len  = sb.block_len();
      n    = sb.block_count();
      addr = $urandom();
      if (pick < 4) cmd = CMD_INIT;
      else if (pick < 8) cmd = CMD_NOP;
      else if (pick < 52) cmd = CMD_ALLOC;
      else begin
        cmd  = CMD_FREE;
        pick = $urandom_range(99);
        if (pick < 65 && sb.held_q.size() > 0) begin
          pick = $urandom_range(sb.held_q.size() - 1);
          addr = sb.held_q[pick];
          sb.held_q.delete(pick);
        end else if (pick < 85 && n > 0) begin
          addr = sb.base_addr + 32'($urandom_range(n - 1) * len);
        end else begin
          case ($urandom_range(4))
            0: addr = '0;
            1: addr = sb.base_addr + 32'($urandom_range(1, 3));
            2: addr = sb.base_addr - 32'($urandom_range(1, 64) * 4);
            3: addr = sb.base_addr + 32'(sb.pool_len);
            default: ;
          endcase
        end
      end
      send_cmd(cmd, addr, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: base 0, 32 blocks of 32 bytes
    send_cmd(CMD_ALLOC, 32'h0, 1'b0);          // empty before any init
    send_cmd(CMD_NOP,   32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_FREE,  32'd32, 1'b0);         // append into an empty list
    send_cmd(CMD_ALLOC, 32'h0, 1'b0);
    send_cmd(CMD_INIT,  32'h0, 1'b0);
    send_cmd(CMD_ALLOC, 32'h0, 1'b0);          // block 0 at address 0
    send_cmd(CMD_ALLOC, 32'h0, 1'b1);
    send_cmd(CMD_FREE,  32'd0, 1'b1);          // null
    send_cmd(CMD_FREE,  32'd33, 1'b0);         // misaligned
    send_cmd(CMD_FREE,  32'd1024, 1'b0);       // past the end
    send_cmd(CMD_FREE,  32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_FREE,  32'd992, 1'b1);        // double free, at head
    send_cmd(CMD_FREE,  32'd992, 1'b0);        // and again at tail
    send_cmd(CMD_FREE,  32'd32, 1'b1);
    send_cmd(CMD_ALLOC, 32'h0, 1'b0);
    send_cmd(CMD_ALLOC, 32'h0, 1'b0);
    send_cmd(CMD_NOP,   32'h0, 1'b0);

    no_idle = 1'b1;
    begin_phase(32'h0000_1000, 24'd1024, 16'd32, 1'b1);
    random_run(180);
    no_idle = 1'b0;

    // 4-byte blocks clamped to full capacity, addresses wrap past 2^32
    begin_phase(32'hFFFF_FF00, 24'hFF_FFFF, 16'd1, 1'b1);
    random_run(180);
    begin_phase(32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 1'b1);
    random_run(180);
    // empty pool, list from the last phase still linked
    begin_phase(32'h8000_0000, 24'd0, 16'd100, 1'b0);
    random_run(150);
    // zero block length
    begin_phase(32'h0000_0010, 24'd200, 16'd0, 1'b1);
    random_run(120);

    // two blocks, push block 1 again at head to make the list cyclic
    begin_phase(32'h0000_0100, 24'd8, 16'd4, 1'b1);
    send_cmd(CMD_FREE, 32'h0000_0104, 1'b1);
    repeat (5) send_cmd(CMD_ALLOC, 32'h0, 1'b0);
    random_run(150);

    begin_phase(32'h0000_0000, 24'hFF_FFFF, 16'd3, 1'b1);
    random_run(180);
    repeat (2) begin
      begin_phase($urandom(), 24'($urandom_range(4096)), 16'($urandom_range(1, 80)),
                  1'($urandom_range(3) != 0));
      random_run(110);
    end

    wait_idle(300);
    if (sb.failures == 0 && sb.pending() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
